/* rtl/core/rbvs_pkg.sv */
// ----------------------------------------------------------------------------
// rbvs_pkg
// Shared types, constants and controller interface for the radial binned
// visibility statistics block.
// ----------------------------------------------------------------------------
`default_nettype none

package rbvs_pkg;

    localparam int MAX_DISCS = 16;
    localparam int DISC_W    = $clog2(MAX_DISCS);
    localparam int DCOUNT_W  = 5;
    localparam int WIDTH_W   = 16;
    localparam int EDGE_W    = 20;
    localparam int DIV_STEPS = 48;
    localparam int SQRT_STEPS = 32;

    localparam logic [0:0] CFG_RING_WIDTH = 1'b0;
    localparam logic [0:0] CFG_DISC_COUNT = 1'b1;

    localparam logic OP_ACCUMULATE = 1'b0;
    localparam logic OP_READ       = 1'b1;

    typedef struct packed {
        logic               opcode;
        logic signed [31:0] coord_u;
        logic signed [31:0] coord_v;
        logic signed [31:0] real_part;
        logic signed [31:0] imag_part;
        logic signed [31:0] weight;
        logic [3:0]         disc_select;
    } in_t;

    typedef struct packed {
        logic [3:0]         disc_index;
        logic [31:0]        sample_count;
        logic signed [31:0] mean_real;
        logic signed [31:0] mean_imag;
        logic [31:0]        power;
        logic signed [47:0] noise_sum;
    } out_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ_MUL,
        ST_SQ_ADD,
        ST_SR_MUL,
        ST_SR_CMP,
        ST_UPDATE,
        ST_RD_LOAD,
        ST_RD_DIV_RE,
        ST_RD_DIV_IM,
        ST_RD_OUT
    } state_t;

    typedef struct packed {
        logic load;
        logic sq_mul;
        logic sq_add;
        logic sr_mul;
        logic sr_cmp;
        logic update;
        logic rd_load;
        logic cap_re;
        logic cap_im;
        logic out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic is_read;
        logic sq_last;
        logic sr_none;
        logic sr_last;
        logic div_busy;
        logic sqrt_busy;
        logic out_busy;
    } ctrl_sts_t;

    // Magnitude of a 32-bit two's complement value; the most negative value
    // maps to 2^31, which still fits in 32 unsigned bits.
    function automatic logic [31:0] mag32(input logic signed [31:0] x);
        logic [31:0] r;
        r = x[31] ? (~x + 32'd1) : x;
        return r;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/rbvs_div.sv */
// ----------------------------------------------------------------------------
// rbvs_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rbvs_div
    import rbvs_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [47:0] dividend,
    input  wire logic [31:0] divisor,
    output logic             busy,
    output logic [47:0]      quotient
);

    logic [47:0] quot_reg, quot_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] dvs_reg;
    logic [5:0]  step_reg, step_next;
    logic        busy_reg, busy_next;
    logic [32:0] trial;
    logic        fits;

    always_comb begin
        trial     = {rem_reg, quot_reg[47]};
        fits      = (trial >= {1'b0, dvs_reg});
        rem_next  = fits ? 32'(trial - {1'b0, dvs_reg}) : trial[31:0];
        quot_next = {quot_reg[46:0], fits};
        step_next = step_reg + 6'd1;
        busy_next = (step_reg != 6'(DIV_STEPS - 1));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            step_reg <= '0;
        end else if (busy_reg) begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quot_reg <= dividend;
            rem_reg  <= '0;
            dvs_reg  <= divisor;
        end else if (busy_reg) begin
            quot_reg <= quot_next;
            rem_reg  <= rem_next;
        end
    end

    assign busy     = busy_reg;
    assign quotient = quot_reg;

endmodule

`default_nettype wire

/* rtl/core/rbvs_sqrt.sv */
// ----------------------------------------------------------------------------
// rbvs_sqrt
// Integer square root of a 64-bit value, two radicand bits per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rbvs_sqrt
    import rbvs_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [63:0] radicand,
    output logic             busy,
    output logic [31:0]      root
);

    logic [63:0] x_reg;
    logic [33:0] rem_reg, rem_next;
    logic [31:0] root_reg, root_next;
    logic [4:0]  step_reg;
    logic        busy_reg;
    logic [35:0] shifted;
    logic [35:0] trial;

    always_comb begin
        shifted = {rem_reg, x_reg[63:62]};
        trial   = {2'b00, root_reg, 2'b01};
        if (shifted >= trial) begin
            rem_next  = 34'(shifted - trial);
            root_next = {root_reg[30:0], 1'b1};
        end else begin
            rem_next  = shifted[33:0];
            root_next = {root_reg[30:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            step_reg <= '0;
        end else if (busy_reg) begin
            busy_reg <= (step_reg != 5'(SQRT_STEPS - 1));
            step_reg <= step_reg + 5'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            x_reg    <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (busy_reg) begin
            x_reg    <= {x_reg[61:0], 2'b00};
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    assign busy = busy_reg;
    assign root = root_reg;

endmodule

`default_nettype wire

/* rtl/core/rbvs_ctrl.sv */
// ----------------------------------------------------------------------------
// rbvs_ctrl
// Sequencing state machine: squaring, disc search, store update and the
// read path with its divider and square root.
// ----------------------------------------------------------------------------
`default_nettype none

module rbvs_ctrl
    import rbvs_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire ctrl_sts_t sts,
    output ctrl_cmd_t      cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_SQ_MUL;
                end
            end
            ST_SQ_MUL: begin
                state_next = sts.is_read ? ST_RD_LOAD : ST_SQ_ADD;
            end
            ST_SQ_ADD: begin
                if (!sts.sq_last) begin
                    state_next = ST_SQ_MUL;
                end else if (sts.sr_none) begin
                    state_next = ST_UPDATE;
                end else begin
                    state_next = ST_SR_MUL;
                end
            end
            ST_SR_MUL: state_next = ST_SR_CMP;
            ST_SR_CMP: begin
                state_next = sts.sr_last ? ST_UPDATE : ST_SR_MUL;
            end
            ST_UPDATE:  state_next = ST_IDLE;
            ST_RD_LOAD: state_next = ST_RD_DIV_RE;
            ST_RD_DIV_RE: begin
                if (!sts.div_busy) begin
                    state_next = ST_RD_DIV_IM;
                end
            end
            ST_RD_DIV_IM: begin
                if (!sts.div_busy && !sts.sqrt_busy) begin
                    state_next = ST_RD_OUT;
                end
            end
            ST_RD_OUT: begin
                if (!sts.out_busy) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            ST_SQ_MUL: cmd.sq_mul = !sts.is_read;
            ST_SQ_ADD: cmd.sq_add = 1'b1;
            ST_SR_MUL: cmd.sr_mul = 1'b1;
            ST_SR_CMP: cmd.sr_cmp = 1'b1;
            ST_UPDATE: cmd.update = 1'b1;
            ST_RD_LOAD: cmd.rd_load = 1'b1;
            ST_RD_DIV_RE: cmd.cap_re = !sts.div_busy;
            ST_RD_DIV_IM: cmd.cap_im = !sts.div_busy && !sts.sqrt_busy;
            ST_RD_OUT: cmd.out_load = !sts.out_busy;
            default: cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

/* rtl/core/rbvs_datapath.sv */
// ----------------------------------------------------------------------------
// rbvs_datapath
// Item registers, shared multiplier, per-disc stores, divider, square root
// and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rbvs_datapath
    import rbvs_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       cfg_wr_en,
    input  wire logic [0:0] cfg_index,
    input  wire logic [15:0] cfg_wdata,
    input  wire in_t        s_data,
    output out_t            m_data,
    output logic            m_valid,
    input  wire logic       m_ready,
    input  wire ctrl_cmd_t  cmd,
    output ctrl_sts_t       sts
);

    logic [WIDTH_W-1:0]  ring_width_reg;
    logic [DCOUNT_W-1:0] disc_count_reg;
    logic [DISC_W-1:0]   last_k;

    in_t         item_reg;
    logic [1:0]  sq_step_reg;
    logic [63:0] prod_reg;
    logic [63:0] r2_reg;
    logic [63:0] p_reg;
    logic [31:0] op_a;

    logic [EDGE_W-1:0] edge_reg;
    logic [DISC_W-1:0] k_reg;
    logic [DISC_W-1:0] best_reg;

    logic [31:0]        count_mem  [MAX_DISCS];
    logic signed [47:0] rsum_mem   [MAX_DISCS];
    logic signed [47:0] isum_mem   [MAX_DISCS];
    logic signed [47:0] wsum_mem   [MAX_DISCS];
    logic [63:0]        sqsum_mem  [MAX_DISCS];

    logic [31:0]        cnt_reg;
    logic signed [47:0] is_reg;
    logic signed [47:0] ws_reg;
    logic signed [31:0] mean_re_reg;
    logic signed [31:0] mean_im_reg;

    logic               div_start;
    logic [47:0]        div_dividend;
    logic [47:0]        div_quot;
    logic               div_busy;
    logic               sqrt_busy;
    logic [31:0]        sqrt_root;
    logic               rd_neg_reg;
    logic signed [31:0] mean_val;

    logic               m_valid_reg;
    out_t               m_data_reg;

    // Saturating add of a 32-bit sample to a 48-bit sum.
    function automatic logic signed [47:0] add_sat48(input logic signed [47:0] a,
                                                     input logic signed [31:0] b);
        logic [48:0] s;
        logic [47:0] r;
        s = {a[47], a} + {{17{b[31]}}, b};
        if (s[48] != s[47]) begin
            r = s[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
        end else begin
            r = s[47:0];
        end
        return r;
    endfunction

    function automatic logic [47:0] mag48(input logic signed [47:0] x);
        logic [47:0] r;
        r = x[47] ? (~x + 48'd1) : x;
        return r;
    endfunction

    // ---------------- configuration ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ring_width_reg <= WIDTH_W'(1);
            disc_count_reg <= DCOUNT_W'(1);
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_RING_WIDTH: ring_width_reg <= cfg_wdata;
                CFG_DISC_COUNT: disc_count_reg <= cfg_wdata[DCOUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // A count of zero acts as one disc and anything above the store depth
    // is clipped to it.
    always_comb begin
        if (disc_count_reg == '0) begin
            last_k = '0;
        end else if (disc_count_reg > DCOUNT_W'(MAX_DISCS)) begin
            last_k = DISC_W'(MAX_DISCS - 1);
        end else begin
            last_k = DISC_W'(disc_count_reg - DCOUNT_W'(1));
        end
    end

    // ---------------- squaring and search ----------------
    always_comb begin
        if (cmd.sr_mul) begin
            op_a = 32'(edge_reg);
        end else begin
            unique case (sq_step_reg)
                2'd0: op_a = mag32(item_reg.coord_u);
                2'd1: op_a = mag32(item_reg.coord_v);
                2'd2: op_a = mag32(item_reg.real_part);
                2'd3: op_a = mag32(item_reg.imag_part);
                default: op_a = '0;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            item_reg    <= s_data;
            sq_step_reg <= '0;
            r2_reg      <= '0;
            p_reg       <= '0;
            k_reg       <= DISC_W'(1);
            edge_reg    <= EDGE_W'(ring_width_reg);
            best_reg    <= '0;
        end
        if (cmd.sq_mul || cmd.sr_mul) begin
            prod_reg <= 64'(op_a) * 64'(op_a);
        end
        if (cmd.sq_add) begin
            if (!sq_step_reg[1]) begin
                r2_reg <= r2_reg + prod_reg;
            end else begin
                p_reg <= p_reg + prod_reg;
            end
            sq_step_reg <= sq_step_reg + 2'd1;
        end
        if (cmd.sr_cmp) begin
            // Edge squared compared with the integer part of u^2+v^2.
            if (prod_reg[40:0] <= {9'd0, r2_reg[63:32]}) begin
                best_reg <= k_reg;
            end
            k_reg    <= k_reg + DISC_W'(1);
            edge_reg <= edge_reg + EDGE_W'(ring_width_reg);
        end
    end

    // ---------------- per-disc stores ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MAX_DISCS; i++) begin
                count_mem[i] <= '0;
                rsum_mem[i]  <= '0;
                isum_mem[i]  <= '0;
                wsum_mem[i]  <= '0;
                sqsum_mem[i] <= '0;
            end
        end else if (cmd.update) begin
            if (count_mem[best_reg] != 32'hFFFF_FFFF) begin
                count_mem[best_reg] <= count_mem[best_reg] + 32'd1;
            end
            rsum_mem[best_reg] <= add_sat48(rsum_mem[best_reg], item_reg.real_part);
            isum_mem[best_reg] <= add_sat48(isum_mem[best_reg], item_reg.imag_part);
            wsum_mem[best_reg] <= add_sat48(wsum_mem[best_reg], item_reg.weight);
            if ({1'b0, sqsum_mem[best_reg]} + {1'b0, p_reg} > 65'h0_FFFF_FFFF_FFFF_FFFF) begin
                sqsum_mem[best_reg] <= '1;
            end else begin
                sqsum_mem[best_reg] <= sqsum_mem[best_reg] + p_reg;
            end
        end
    end

    // ---------------- read path ----------------
    assign div_start    = cmd.rd_load || cmd.cap_re;
    assign div_dividend = cmd.rd_load ? mag48(rsum_mem[item_reg.disc_select]) : mag48(is_reg);

    always_comb begin
        if (cnt_reg == '0) begin
            mean_val = '0;
        end else if (rd_neg_reg) begin
            mean_val = (div_quot > 48'h0000_8000_0000) ? 32'sh8000_0000
                                                       : 32'(~div_quot + 48'd1);
        end else begin
            mean_val = (div_quot > 48'h0000_7FFF_FFFF) ? 32'sh7FFF_FFFF
                                                       : div_quot[31:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.rd_load) begin
            cnt_reg    <= count_mem[item_reg.disc_select];
            is_reg     <= isum_mem[item_reg.disc_select];
            ws_reg     <= wsum_mem[item_reg.disc_select];
            rd_neg_reg <= rsum_mem[item_reg.disc_select][47];
        end
        if (cmd.cap_re) begin
            mean_re_reg <= mean_val;
            rd_neg_reg  <= is_reg[47];
        end
        if (cmd.cap_im) begin
            mean_im_reg <= mean_val;
        end
    end

    rbvs_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (cmd.rd_load ? count_mem[item_reg.disc_select] : cnt_reg),
        .busy     (div_busy),
        .quotient (div_quot)
    );

    rbvs_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.rd_load),
        .radicand (sqsum_mem[item_reg.disc_select]),
        .busy     (sqrt_busy),
        .root     (sqrt_root)
    );

    // ---------------- output register ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_data_reg.disc_index   <= item_reg.disc_select;
            m_data_reg.sample_count <= cnt_reg;
            m_data_reg.mean_real    <= mean_re_reg;
            m_data_reg.mean_imag    <= mean_im_reg;
            m_data_reg.power        <= sqrt_root;
            m_data_reg.noise_sum    <= ws_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign sts.is_read   = (item_reg.opcode == OP_READ);
    assign sts.sq_last   = (sq_step_reg == 2'd3);
    assign sts.sr_none   = (last_k == '0);
    assign sts.sr_last   = (k_reg == last_k);
    assign sts.div_busy  = div_busy;
    assign sts.sqrt_busy = sqrt_busy;
    assign sts.out_busy  = m_valid_reg && !m_ready;

endmodule

`default_nettype wire

/* rtl/core/radial_bin_visibility_stats.sv */
// ----------------------------------------------------------------------------
// radial_bin_visibility_stats
// Sorts visibilities into radial discs and reports per-disc statistics.
// ----------------------------------------------------------------------------
// An accumulate transaction squares u, v, real and imaginary parts on one
// shared 32x32 multiplier, steps through the disc edges with a multiply
// and a compare per disc, updates one store entry and returns nothing.
// A read transaction returns one result; the one-bit-per-cycle divider
// forms the real and then the imaginary mean, and the square root runs
// alongside the first division. One transaction is in the block at a time;
// a finished result waits in the output register while the next
// transaction is taken. All stores are cleared by reset.
`default_nettype none

module radial_bin_visibility_stats
    import rbvs_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [15:0] cfg_wdata,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire in_t         s_data,
    output logic             m_valid,
    input  wire logic        m_ready,
    output out_t             m_data
);

    ctrl_cmd_t cmd;
    ctrl_sts_t sts;

    rbvs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    rbvs_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_data    (s_data),
        .m_data    (m_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

`default_nettype wire

/* rtl/core/rbvs_checker.sv */
// ----------------------------------------------------------------------------
// rbvs_checker
// Port-level checks for the radial binned visibility statistics block.
// ----------------------------------------------------------------------------
`default_nettype none

module rbvs_checker
    import rbvs_pkg::*;
(
    input wire logic aclk,
    input wire logic aresetn,
    input wire logic s_valid,
    input wire logic s_ready,
    input wire in_t  s_data,
    input wire logic m_valid,
    input wire logic m_ready,
    input wire out_t m_data
);

    // A stalled result stays put.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // A waiting transaction on the input stays offered and unchanged.
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_data))
        else $error("input transaction changed while waiting");

    // The block holds one transaction at a time, so the input closes after one.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input open right after a transaction");

    // An empty disc has nothing to report.
    a_empty_disc: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.sample_count == 32'd0 |->
            m_data.mean_real == 32'sd0 && m_data.mean_imag == 32'sd0 &&
            m_data.power == 32'd0 && m_data.noise_sum == 48'sd0)
        else $error("empty disc reports non-zero statistics");

    // No result is shown straight after reset.
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind radial_bin_visibility_stats rbvs_checker u_rbvs_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Randomised check of the radial binned visibility statistics block: a
// queue-fed driver offers accumulate and read transactions, a monitor
// compares every result against a local prediction of the disc stores.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
    import rbvs_pkg::*;

    localparam longint S48_MAX = 64'sh7FFF_FFFF_FFFF;
    localparam longint S48_MIN = -64'sh8000_0000_0000;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [0:0]  cfg_index;
    logic [15:0] cfg_wdata;
    logic        s_valid;
    logic        s_ready;
    in_t         s_data;
    logic        m_valid;
    logic        m_ready;
    out_t        m_data;

    radial_bin_visibility_stats i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // Predicted state of the block.
    logic [15:0]    width_reg;
    logic [4:0]     discs_reg;
    logic [31:0]    disc_count_tab [MAX_DISCS];
    longint         real_sum_tab   [MAX_DISCS];
    longint         imag_sum_tab   [MAX_DISCS];
    longint         wsum_tab       [MAX_DISCS];
    longint unsigned sq_sum_tab    [MAX_DISCS];

    in_t  pending_items [$];
    out_t expected_stats [$];
    int   mismatches;
    int   reads_seen;
    int   accums_sent;
    bit   hold_off;

    initial begin
        aclk = 1'b0;
    end
    always #6 aclk = ~aclk;

    function automatic longint sat48(input longint a, input longint b);
        longint s;
        s = a + b;
        if (s > S48_MAX) return S48_MAX;
        if (s < S48_MIN) return S48_MIN;
        return s;
    endfunction

    function automatic longint unsigned sq_of(input logic signed [31:0] x);
        longint unsigned m;
        m = x[31] ? 64'(-longint'(x)) : 64'(x);
        return m * m;
    endfunction

    function automatic longint unsigned root64(input longint unsigned x);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [31:0] average(input longint s, input logic [31:0] n);
        longint q;
        if (n == 0) return 32'd0;
        q = s / longint'({32'd0, n});
        if (q > 64'sh7FFF_FFFF) q = 64'sh7FFF_FFFF;
        if (q < -64'sh8000_0000) q = -64'sh8000_0000;
        return q[31:0];
    endfunction

    function automatic int disc_for(input longint unsigned r2);
        int n, best;
        longint unsigned e, q;
        n = int'(discs_reg);
        best = 0;
        if (n == 0) n = 1;
        if (n > MAX_DISCS) n = MAX_DISCS;
        for (int k = 0; k < n; k++) begin
            e = longint'(k) * width_reg;
            q = e * e;
            if (q <= 64'h8000_0000 && (q << 32) <= r2) best = k;
        end
        return best;
    endfunction

    // Applies one accepted transaction to the predicted stores.
    task automatic apply_item(input in_t it);
        int d, sel;
        longint unsigned p;
        out_t r;
        if (it.opcode == OP_ACCUMULATE) begin
            d = disc_for(sq_of(it.coord_u) + sq_of(it.coord_v));
            p = sq_of(it.real_part) + sq_of(it.imag_part);
            if (disc_count_tab[d] != 32'hFFFF_FFFF) disc_count_tab[d]++;
            real_sum_tab[d] = sat48(real_sum_tab[d], longint'(it.real_part));
            imag_sum_tab[d] = sat48(imag_sum_tab[d], longint'(it.imag_part));
            wsum_tab[d]     = sat48(wsum_tab[d], longint'(it.weight));
            if (sq_sum_tab[d] > 64'hFFFF_FFFF_FFFF_FFFF - p)
                sq_sum_tab[d] = 64'hFFFF_FFFF_FFFF_FFFF;
            else
                sq_sum_tab[d] += p;
        end else begin
            sel = int'(it.disc_select);
            r.disc_index   = it.disc_select;
            r.sample_count = disc_count_tab[sel];
            r.mean_real    = average(real_sum_tab[sel], disc_count_tab[sel]);
            r.mean_imag    = average(imag_sum_tab[sel], disc_count_tab[sel]);
            r.power        = 32'(root64(sq_sum_tab[sel]));
            r.noise_sum    = wsum_tab[sel][47:0];
            expected_stats.push_back(r);
        end
    endtask

    function automatic int gap_len();
        int c;
        c = $urandom_range(0, 99);
        if (c < 40) return 0;
        if (c < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Driver: offers queued transactions with random gaps.
    int src_gap;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_data  <= '0;
            src_gap <= 0;
        end else if (s_valid && !s_ready) begin
            // hold the offer
        end else begin
            if (s_valid && s_ready) apply_item(s_data);
            if (src_gap > 0) begin
                src_gap <= src_gap - 1;
                s_valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
                s_data  <= pending_items.pop_front();
                s_valid <= 1'b1;
                src_gap <= gap_len();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Monitor and result-side stalls.
    int sink_gap;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready  <= 1'b0;
            sink_gap <= 0;
        end else begin
            if (m_valid && m_ready) begin
                reads_seen++;
                if (expected_stats.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result %p", m_data);
                end else begin
                    out_t e;
                    e = expected_stats.pop_front();
                    if (e !== m_data) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch disc %0d: expected %p, got %p",
                                     e.disc_index, e, m_data);
                    end
                end
            end
            if (hold_off) begin
                m_ready <= 1'b0;
            end else if (sink_gap > 0) begin
                sink_gap <= sink_gap - 1;
                m_ready  <= 1'b0;
            end else begin
                m_ready  <= 1'b1;
                sink_gap <= gap_len();
            end
        end
    end

    function automatic logic signed [31:0] rnd_val();
        case ($urandom_range(0, 5))
            0: return 32'sh7FFF_FFFF;
            1: return -32'sh8000_0000;
            2: return $urandom_range(0, 32'h000F_FFFF);
            3: return -$urandom_range(0, 32'h000F_FFFF);
            default: return $urandom;
        endcase
    endfunction

    // Coordinates near disc edges for the current ring width.
    function automatic logic signed [31:0] rnd_coord();
        longint c;
        if ($urandom_range(0, 3) == 0) return rnd_val();
        c = longint'($urandom_range(0, 17)) * width_reg * 65536
            + $urandom_range(0, 3) - 2;
        if (c > 64'sh7FFF_FFFF) c = 64'sh7FFF_FFFF;
        if (c < 0) c = 0;
        if ($urandom_range(0, 1)) c = -c;
        return c[31:0];
    endfunction

    function automatic in_t make_accum();
        in_t it;
        it.opcode      = OP_ACCUMULATE;
        it.coord_u     = rnd_coord();
        it.coord_v     = rnd_coord();
        it.real_part   = rnd_val();
        it.imag_part   = rnd_val();
        it.weight      = rnd_val();
        it.disc_select = 4'($urandom);
        return it;
    endfunction

    function automatic in_t make_read(input logic [3:0] sel);
        in_t it;
        it = make_accum();
        it.opcode      = OP_READ;
        it.disc_select = sel;
        return it;
    endfunction

    task automatic wait_idle();
        while (pending_items.size() > 0 || s_valid || expected_stats.size() > 0)
            @(posedge aclk);
        repeat (150) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [15:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == CFG_RING_WIDTH) width_reg = val;
        else discs_reg = val[4:0];
        @(posedge aclk);
    endtask

    initial begin
        in_t it;
        logic [15:0] wd [6];
        logic [15:0] dc [6];
        wd = '{16'd1, 16'd65535, 16'd0, 16'd3, 16'd200, 16'd40};
        dc = '{16'd16, 16'd1, 16'd16, 16'd0, 16'd31, 16'd7};
        width_reg = 16'd1;
        discs_reg = 5'd1;
        for (int k = 0; k < MAX_DISCS; k++) begin
            disc_count_tab[k] = 0;
            real_sum_tab[k] = 0;
            imag_sum_tab[k] = 0;
            wsum_tab[k] = 0;
            sq_sum_tab[k] = 0;
        end
        mismatches = 0;
        reads_seen = 0;
        accums_sent = 0;
        hold_off = 1'b0;
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: reset-value reads, extremes and a zero item, then a read of disc 0.
        pending_items.push_back(make_read(4'd0));
        pending_items.push_back(make_read(4'd15));
        it = make_accum();
        it.coord_u = -32'sh8000_0000; it.coord_v = -32'sh8000_0000;
        it.real_part = -32'sh8000_0000; it.imag_part = -32'sh8000_0000;
        it.weight = -32'sh8000_0000;
        pending_items.push_back(it);
        it.coord_u = 32'sh7FFF_FFFF; it.coord_v = 32'sh7FFF_FFFF;
        it.real_part = 32'sh7FFF_FFFF; it.imag_part = 32'sh7FFF_FFFF;
        it.weight = 32'sh7FFF_FFFF;
        pending_items.push_back(it);
        it = make_accum();
        it.coord_u = 0; it.coord_v = 0; it.real_part = 0; it.imag_part = 0;
        it.weight = 0;
        pending_items.push_back(it);
        pending_items.push_back(make_read(4'd0));
        wait_idle();

        for (int ph = 0; ph < 6; ph++) begin
            write_reg(CFG_RING_WIDTH, wd[ph]);
            write_reg(CFG_DISC_COUNT, dc[ph]);
            for (int k = 0; k < 16; k++) begin
                pending_items.push_back(make_accum());
                accums_sent++;
            end
            for (int k = 0; k < 16; k++) pending_items.push_back(make_read(4'(k)));
            // Long receiver stall while the sender keeps offering.
            if (ph == 1) begin
                hold_off = 1'b1;
                repeat (600) @(posedge aclk);
                hold_off = 1'b0;
            end
            for (int k = 0; k < 55; k++) begin
                if ($urandom_range(0, 9) < 8) begin
                    pending_items.push_back(make_accum());
                    accums_sent++;
                end else begin
                    pending_items.push_back(make_read(4'($urandom)));
                end
            end
            wait_idle();
        end
        $display("covered %0d accumulates and %0d reads over 6 register settings",
                 accums_sent, reads_seen);
        if (mismatches == 0 && expected_stats.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("timeout");
        $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire
